### hw/rtl/lpe_pkg.sv
// Package for the line position estimator: sequencer states, sizes and the
// fixed sensor weight table. No dependencies.
package lpe_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_W     = 8;
    localparam int POS_W        = 6;
    localparam int QUOT_W       = 5;
    localparam int COUNT_W      = 4;
    localparam int IDX_W        = 3;
    localparam int OUT_DATA_W   = 16;

    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = -8'sd26;
    localparam logic signed [POS_W-1:0]    EDGE_LEVEL      = 6'sd9;
    localparam logic [IDX_W-1:0]           LAST_SENSOR     = 3'd7;
    localparam logic [IDX_W-1:0]           LAST_QUOT_BIT   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

    // Weight of each sensor, leftmost sensor most negative.
    function automatic logic signed [POS_W-1:0] sensor_weight(input logic [IDX_W-1:0] idx);
        logic signed [POS_W-1:0] w;
        unique case (idx)
            3'd0:    w = -6'sd16;
            3'd1:    w = -6'sd9;
            3'd2:    w = -6'sd4;
            3'd3:    w = -6'sd1;
            3'd4:    w = 6'sd1;
            3'd5:    w = 6'sd4;
            3'd6:    w = 6'sd9;
            default: w = 6'sd16;
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/line_position_estimator.sv
// Line position estimator top level: threshold register, scan sequencer,
// shared compare/accumulate step and a bit-serial restoring divider.
// Depends on lpe_pkg.

// One input beat carries eight signed 8-bit sensor samples. The block
// compares one sample per cycle against the signed detection threshold,
// accumulating the fixed weight and a hit count for each sensor above it,
// then divides the weighted sum by the hit count one quotient bit per cycle
// (truncating toward zero). After a beat is taken the block scans all
// sensors, divides only when any sensor fired, and then loads the result
// register. It goes back to idle before the next beat is taken, so a new
// beat is never taken before the last one is through. The load waits as
// long as an earlier result still waits for m_tready. The sample loop and
// the divider share the sequencer, so s_tready is high only while it is
// idle. The result register is separate, so a new beat can be taken while
// the previous result waits for m_tready. When no sensor fires and the
// last position was at an edge, the old position is held and the lost
// flag is set.
module line_position_estimator (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: detection threshold, signed.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Input stream. tdata: sample_0 [7:0] up to sample_7 [63:56].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // Result stream. tdata: position [5:0], lost flag [6],
    // sensor_bits [14:7], zero [15].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);
    import lpe_pkg::*;

    // Configuration and architectural state.
    logic signed [SAMPLE_W-1:0] thr_reg;
    logic signed [POS_W-1:0]    prev_pos_reg, prev_pos_next;
    logic                       lost_reg, lost_next;

    // Sequencer and datapath registers.
    state_t                     state_reg, state_next;
    logic signed [SAMPLE_W-1:0] samples_reg [SENSOR_COUNT];
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic signed [POS_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [SENSOR_COUNT-1:0]    bits_reg, bits_next;
    logic [QUOT_W-1:0]          quot_reg, quot_next;
    logic [IDX_W-1:0]           rem_reg, rem_next;
    logic                       neg_reg, neg_next;

    // Output register.
    logic                       m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]      m_data_reg, m_data_next;

    logic                       in_beat;
    logic                       out_free;
    logic                       hit;
    logic signed [POS_W-1:0]    sum_step;
    logic [COUNT_W-1:0]         count_step;
    logic signed [POS_W-1:0]    sum_abs;
    logic [COUNT_W-1:0]         trial;
    logic                       trial_ge;
    logic signed [POS_W-1:0]    pos_final;
    logic                       lost_final;
    logic                       at_edge;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The shared compare/accumulate step for the sensor picked by idx_reg.
    assign hit        = samples_reg[idx_reg] > thr_reg;
    assign sum_step   = hit ? sum_reg + sensor_weight(idx_reg) : sum_reg;
    assign count_step = hit ? count_reg + COUNT_W'(1) : count_reg;
    assign sum_abs    = sum_step[POS_W-1] ? -sum_step : sum_step;

    // One restoring-divide step: the remainder stays below the count.
    assign trial    = {rem_reg, quot_reg[QUOT_W-1]};
    assign trial_ge = trial >= count_reg;

    // Final position and lost flag.
    assign at_edge = (prev_pos_reg >= EDGE_LEVEL) || (prev_pos_reg <= -EDGE_LEVEL);
    always_comb begin
        if (count_reg != '0) begin
            pos_final  = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
            lost_final = 1'b0;
        end else if (at_edge) begin
            pos_final  = prev_pos_reg;
            lost_final = 1'b1;
        end else begin
            pos_final  = '0;
            lost_final = lost_reg;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == LAST_SENSOR) begin
                    state_next = (count_step != '0) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (idx_reg == LAST_QUOT_BIT) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        bits_next     = bits_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        prev_pos_next = prev_pos_reg;
        lost_next     = lost_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next   = '0;
                sum_next   = '0;
                count_next = '0;
                bits_next  = '0;
            end
            ST_SCAN: begin
                sum_next          = sum_step;
                count_next        = count_step;
                bits_next[idx_reg] = hit;
                if (idx_reg == LAST_SENSOR) begin
                    idx_next  = '0;
                    quot_next = sum_abs[QUOT_W-1:0];
                    rem_next  = '0;
                    neg_next  = sum_step[POS_W-1];
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DIV: begin
                idx_next  = idx_reg + IDX_W'(1);
                rem_next  = trial_ge ? IDX_W'(trial - count_reg) : trial[IDX_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], trial_ge};
            end
            ST_DONE: begin
                if (out_free) begin
                    prev_pos_next = pos_final;
                    lost_next     = lost_final;
                    m_valid_next  = 1'b1;
                    m_data_next   = {1'b0, bits_reg, lost_final, pos_final};
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THRESHOLD_RESET;
            prev_pos_reg <= '0;
            lost_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            prev_pos_reg <= prev_pos_next;
            lost_reg     <= lost_next;
            m_valid_reg  <= m_valid_next;
            idx_reg      <= idx_next;
            if (cfg_wr_en) begin
                thr_reg <= $signed(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        bits_reg   <= bits_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
        if (in_beat) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                samples_reg[i] <= $signed(s_tdata[i*SAMPLE_W +: SAMPLE_W]);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A beat that is taken starts the scan at the leftmost sensor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == ST_SCAN) && (idx_reg == '0))
        else $error("scan did not start at sensor 0 after an input beat");

    // The divider only runs with a nonzero hit count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (count_reg != '0) && (count_reg <= COUNT_W'(SENSOR_COUNT)))
        else $error("divider running with an invalid hit count");

    // Reported positions stay within the outermost weights.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[5:0]) >= -6'sd16) && ($signed(m_tdata[5:0]) <= 6'sd16))
        else $error("position out of range");

    // No sensor hit and no lost flag means the position was reset to zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[14:7] == '0) && !m_tdata[6]) |-> (m_tdata[5:0] == '0))
        else $error("empty scan without line loss reported a nonzero position");

endmodule

### sim/scan_result_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the line position estimator. It watches the threshold writes and both
// stream channels, predicts every result beat and compares it. Depends on lpe_pkg.
module scan_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_0 [7:0] .. sample_7 [63:56]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // position [5:0], lost flag [6], sensor_bits [14:7], zero [15]
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    import lpe_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    lost_bit;
        logic [SENSOR_COUNT-1:0] sensor_bits;
    } track_t;

    localparam int WEIGHT [SENSOR_COUNT] = '{-16, -9, -4, -1, 1, 4, 9, 16};

    logic signed [SAMPLE_W-1:0] threshold;
    logic signed [POS_W-1:0]    prev_position;
    logic                       lost;
    track_t                     expected_tracks[$];

    // Weighted mean of the detected sensors; with nothing detected the position is held
    // only when the line was last seen at an edge.
    function automatic track_t estimate_position(input logic [63:0] scan,
                                                 input logic signed [SAMPLE_W-1:0] thr,
                                                 input logic signed [POS_W-1:0] prev_pos,
                                                 input logic prev_lost);
        track_t                     r;
        int                         sum;
        int                         hits;
        logic signed [SAMPLE_W-1:0] sample;
        sum           = 0;
        hits          = 0;
        r.sensor_bits = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sample = scan[i*SAMPLE_W +: SAMPLE_W];
            if (sample > thr) begin
                r.sensor_bits[i] = 1'b1;
                sum  += WEIGHT[i];
                hits += 1;
            end
        end
        if (hits != 0) begin
            r.position = POS_W'(sum / hits);
            r.lost_bit = 1'b0;
        end else if (prev_pos >= EDGE_LEVEL || prev_pos <= -EDGE_LEVEL) begin
            r.position = prev_pos;
            r.lost_bit = 1'b1;
        end else begin
            r.position = '0;
            r.lost_bit = prev_lost;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        track_t want;
        if (!aresetn) begin
            threshold     = THRESHOLD_RESET;
            prev_position = '0;
            lost          = 1'b0;
            expected_tracks.delete();
            fail_count    = 0;
            results_seen  = 0;
        end else begin
            if (cfg_wr_en)
                threshold = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                want          = estimate_position(s_tdata, threshold, prev_position, lost);
                prev_position = want.position;
                lost          = want.lost_bit;
                expected_tracks.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_tracks.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with no scan outstanding: expected none, got 0x%04h",
                             $time, m_tdata);
                end else begin
                    want = expected_tracks.pop_front();
                    if (m_tdata[5:0] !== want.position) begin
                        fail_count++;
                        $display("%0t: position mismatch: expected %0d, got %0d", $time,
                                 want.position, $signed(m_tdata[5:0]));
                    end
                    if (m_tdata[6] !== want.lost_bit) begin
                        fail_count++;
                        $display("%0t: lost flag mismatch: expected %0b, got %0b", $time,
                                 want.lost_bit, m_tdata[6]);
                    end
                    if (m_tdata[14:7] !== want.sensor_bits) begin
                        fail_count++;
                        $display("%0t: sensor_bits mismatch: expected %08b, got %08b", $time,
                                 want.sensor_bits, m_tdata[14:7]);
                    end
                    if (m_tdata[15] !== 1'b0) begin
                        fail_count++;
                        $display("%0t: pad bit mismatch: expected 0, got %0b", $time,
                                 m_tdata[15]);
                    end
                end
            end
        end
        pending = expected_tracks.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Top of the line position estimator testbench: clock, reset, threshold writes and
// scan stimulus. Depends on lpe_pkg, line_position_estimator and scan_result_checker.
module tb;
    import lpe_pkg::*;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;   // sample_0 [7:0] .. sample_7 [63:56]
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // position [5:0], lost flag [6], sensor_bits [14:7], zero [15]

    int fail_count;
    int pending;
    int results_seen;

    // While steady is set neither side inserts idle cycles, so the block runs at full
    // throughput for one whole phase.
    bit                         steady = 1'b0;
    int                         settings_used = 1;
    logic signed [SAMPLE_W-1:0] thr_now = THRESHOLD_RESET;

    // 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    line_position_estimator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    scan_result_checker scan_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // The receiver stalls at random with a probability of 0.38, except in the steady phase.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 38);
    end

    // A scan in which the sensors marked in hits read hi and all others read lo.
    function automatic logic [63:0] pattern_scan(input logic [SENSOR_COUNT-1:0] hits,
                                                 input logic signed [SAMPLE_W-1:0] hi,
                                                 input logic signed [SAMPLE_W-1:0] lo);
        logic [63:0] scan;
        for (int i = 0; i < SENSOR_COUNT; i++)
            scan[i*SAMPLE_W +: SAMPLE_W] = hits[i] ? hi : lo;
        return scan;
    endfunction

    // Mostly well-formed scans: a line one to three sensors wide over a floor that stays
    // at or below the threshold, often pushed to an edge so the line can be lost there.
    // The rest are empty floors (line gone) and pure noise.
    function automatic logic [63:0] random_scan(input logic signed [SAMPLE_W-1:0] thr);
        logic [63:0] scan;
        int          kind;
        int          first;
        int          width;
        int          floor_top;
        floor_top = int'(thr) + 128;
        kind      = $urandom_range(0, 99);
        for (int i = 0; i < SENSOR_COUNT; i++)
            scan[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(int'($urandom_range(floor_top, 0)) - 128);
        if (kind < 15 || thr == 8'sd127)
            return scan;
        if (kind < 35)
            return {$urandom, $urandom};
        width = $urandom_range(1, 3);
        if (kind < 55)
            first = $urandom_range(0, 1) ? 0 : SENSOR_COUNT - width;
        else
            first = $urandom_range(0, SENSOR_COUNT - width);
        for (int i = first; i < first + width; i++)
            scan[i*SAMPLE_W +: SAMPLE_W] =
                SAMPLE_W'(int'($urandom_range(255, floor_top + 1)) - 128);
        return scan;
    endfunction

    // Called and returning at a falling edge. The sender may idle first; once tvalid is
    // raised it holds the beat until the block takes it, and it is left high afterwards
    // so that back-to-back beats never drop tvalid.
    task automatic send_scan(input logic [63:0] scan);
        while (!steady && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= scan;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Every scan yields one result, so once nothing is outstanding the block is idle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic signed [SAMPLE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        thr_now = value;
        settings_used++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset threshold of -26. Each line-lost case is entered
        // from a known position, so holds at both edges and the return to zero from
        // inside the edges are all exercised.
        send_scan(pattern_scan(8'h00, 8'sd127, -8'sd128));  // nothing fires, stays at zero
        send_scan(pattern_scan(8'h01, 8'sd127, -8'sd128));  // leftmost only
        send_scan(pattern_scan(8'h00, 8'sd127, -8'sd128));  // lost at the left edge
        send_scan(pattern_scan(8'h00, 8'sd0,   -8'sd26));   // samples equal the threshold
        send_scan(pattern_scan(8'h80, 8'sd127, -8'sd26));   // rightmost only
        send_scan(pattern_scan(8'h00, 8'sd0,   -8'sd100));  // lost at the right edge
        send_scan(pattern_scan(8'h02, -8'sd25, -8'sd128));  // just above threshold, at -9
        send_scan(pattern_scan(8'h00, 8'sd0,   -8'sd128));  // held at -9
        send_scan(pattern_scan(8'h40, 8'sd50,  -8'sd30));   // exactly +9
        send_scan(pattern_scan(8'h00, 8'sd0,   -8'sd30));   // held at +9
        send_scan(pattern_scan(8'h08, 8'sd90,  -8'sd128));  // -1, inside the edges
        send_scan(pattern_scan(8'h00, 8'sd0,   -8'sd128));  // back to zero, not lost
        send_scan(pattern_scan(8'hF0, 8'sd127, -8'sd128));  // right half, mean 7
        send_scan(pattern_scan(8'h00, 8'sd0,   -8'sd128));  // zero again from inside
        send_scan(pattern_scan(8'hFF, 8'sd127, -8'sd128));  // all sensors, mean 0
        send_scan(pattern_scan(8'h03, 8'sd127, -8'sd128));  // -25/2 truncates to -12
        send_scan(pattern_scan(8'h09, 8'sd127, -8'sd128));  // -17/2 truncates to -8
        send_scan(pattern_scan(8'hE0, 8'sd127, -8'sd128));  // 29/3 truncates to 9
        send_scan(pattern_scan(8'hAA, 8'sd127, -8'sd128));  // alternating, odd sensors
        send_scan(pattern_scan(8'h55, 8'sd127, -8'sd128));  // alternating, even sensors
        drain();

        // Top threshold: no sample can exceed it.
        write_threshold(8'sd127);
        send_scan(pattern_scan(8'hFF, 8'sd127, 8'sd127));
        send_scan(random_scan(thr_now));
        drain();

        // Bottom threshold: only -128 stays dark.
        write_threshold(-8'sd128);
        send_scan(pattern_scan(8'h00, -8'sd128, -8'sd128));
        send_scan(pattern_scan(8'h01, -8'sd127, -8'sd128));
        send_scan(pattern_scan(8'h00, -8'sd128, -8'sd128));
        send_scan(pattern_scan(8'hFF, -8'sd127, -8'sd127));
        drain();

        // Random part: eight phases of 50 scans, each at its own threshold.
        for (int phase = 0; phase < 8; phase++) begin
            write_threshold(phase == 0 ? 8'sd0 : SAMPLE_W'($urandom_range(0, 255)));
            steady = (phase == 3);
            for (int n = 0; n < 50; n++)
                send_scan(random_scan(thr_now));
            drain();
            steady = 1'b0;
        end

        repeat (30) @(negedge aclk);
        $display("Checked %0d result beats over %0d threshold settings, edge holds included.",
                 results_seen, settings_used);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Far beyond the slowest correct run of about 430 scans plus stalls.
    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lpe_pkg.sv
hw/rtl/line_position_estimator.sv
sim/scan_result_checker.sv
sim/tb.sv
